>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the escape parser.
// Every macro assumes a clock i_clk in scope; the first two also an active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ACSI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define ACSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also runs through reset.
`define ACSI_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/acsi_pkg.sv
// Shared types, constants and small decode functions of the escape parser.
// No dependencies; every other RTL file but acsi_if imports this package.
`default_nettype none

package acsi_pkg;

    // defaults for the top-level parameters
    localparam int unsigned DIGIT_LIMIT_DEF = 8;
    localparam int unsigned ARG_SLOTS_DEF   = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // configuration port
    localparam int unsigned PADDR_W        = 3;
    localparam logic [PADDR_W-3:0] REG_LINE_WIDTH = '0;
    localparam logic [7:0] LINE_WIDTH_RST  = 8'd80;

    // characters
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UP     = 8'h41;  // A
    localparam logic [7:0] CH_DOWN   = 8'h42;  // B
    localparam logic [7:0] CH_RIGHT  = 8'h43;  // C
    localparam logic [7:0] CH_LEFT   = 8'h44;  // D
    localparam logic [7:0] CH_HOME   = 8'h48;  // H
    localparam logic [7:0] CH_CLEAR  = 8'h4A;  // J
    localparam logic [7:0] CH_ERASE  = 8'h4B;  // K
    localparam logic [7:0] CH_HVP    = 8'h66;  // f
    localparam logic [7:0] CH_SGR    = 8'h6D;  // m
    localparam logic [7:0] CH_SAVE   = 8'h73;  // s
    localparam logic [7:0] CH_RESTORE = 8'h75; // u

    // argument values
    localparam logic [15:0] SGR_RESET = 16'd0;
    localparam logic [15:0] SGR_BLINK = 16'd5;
    localparam logic [15:0] SGR_FG_LO = 16'd30;
    localparam logic [15:0] SGR_FG_HI = 16'd37;
    localparam logic [15:0] SGR_BG_LO = 16'd40;
    localparam logic [15:0] SGR_BG_HI = 16'd47;
    localparam logic [15:0] CLEAR_ALL = 16'd2;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_BRACKET,
        MODE_PARAMS
    } t_mode;

    typedef enum logic [3:0] {
        ACT_NONE     = 4'd0,
        ACT_SET_ROW  = 4'd1,
        ACT_SET_COL  = 4'd2,
        ACT_SET_BOTH = 4'd3,
        ACT_ERASE    = 4'd4,
        ACT_CLEAR    = 4'd5,
        ACT_BLINK    = 4'd6,
        ACT_FG       = 4'd7,
        ACT_BG       = 4'd8
    } t_action;

    // one result's action and attribute
    typedef struct packed {
        t_action    action;
        logic [3:0] attr;
    } t_slot;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [3:0] fg_colour(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0: c = 4'd0;
            3'd1: c = 4'd4;
            3'd2: c = 4'd2;
            3'd3: c = 4'd14;
            3'd4: c = 4'd1;
            3'd5: c = 4'd5;
            3'd6: c = 4'd3;
            default: c = 4'd15;
        endcase
        return c;
    endfunction

    // brown and light grey in place of yellow and white
    function automatic logic [3:0] bg_colour(input logic [2:0] idx);
        logic [3:0] c;
        case (idx)
            3'd0: c = 4'd0;
            3'd1: c = 4'd4;
            3'd2: c = 4'd2;
            3'd3: c = 4'd6;
            3'd4: c = 4'd1;
            3'd5: c = 4'd5;
            3'd6: c = 4'd3;
            default: c = 4'd7;
        endcase
        return c;
    endfunction

    function automatic t_slot sgr_decode(input logic [15:0] v);
        t_slot      s;
        logic [15:0] d_fg;
        logic [15:0] d_bg;
        d_fg = v - SGR_FG_LO;
        d_bg = v - SGR_BG_LO;
        s.action = ACT_NONE;
        s.attr   = 4'd0;
        if (v == SGR_RESET) begin
            s.action = ACT_BLINK;
        end else if (v == SGR_BLINK) begin
            s.action = ACT_BLINK;
            s.attr   = 4'd1;
        end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
            s.action = ACT_FG;
            s.attr   = fg_colour(d_fg[2:0]);
        end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
            s.action = ACT_BG;
            s.attr   = bg_colour(d_bg[2:0]);
        end
        return s;
    endfunction

    function automatic logic [7:0] sat8(input logic [16:0] v);
        return (|v[16:8]) ? 8'hFF : v[7:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/acsi_if.sv
// Valid/ready channel interfaces for character words in and result words out.
// Standalone; used by the front end, the back end and the top level.
`default_nettype none

interface acsi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic [7:0] cur_row;
    logic [7:0] cur_col;

    modport source (output valid, output ch, output cur_row, output cur_col, input ready);
    modport sink   (input valid, input ch, input cur_row, input cur_col, output ready);
endinterface

interface acsi_out_if;
    logic       valid;
    logic       ready;
    logic       consumed;
    logic [3:0] action;
    logic [7:0] row;
    logic [7:0] col;
    logic [3:0] attr_value;
    logic       last;

    modport source (output valid, output consumed, output action, output row, output col,
                    output attr_value, output last, input ready);
    modport sink   (input valid, input consumed, input action, input row, input col,
                    input attr_value, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/acsi_queue.sv
// Short register queue between the parser front end and the result sequencer.
// Depends on acsi_pkg for the status struct.
`default_nettype none

module acsi_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = acsi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_data,
    output acsi_pkg::t_q_status    o_status
);
    import acsi_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/acsi_front.sv
// Parser front end: takes character words, tracks the CSI sequence and
// turns each character into one queued command. Depends on acsi_pkg, acsi_if.
`default_nettype none

module acsi_front #(
    parameter int unsigned DIGIT_LIMIT = acsi_pkg::DIGIT_LIMIT_DEF,
    parameter int unsigned ARG_SLOTS   = acsi_pkg::ARG_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    acsi_in_if.sink                            i_in,
    input  logic [7:0]                         i_line_width,
    input  logic                               i_full,
    output logic                               o_push,
    output logic                               o_cmd_cons,
    output logic [7:0]                         o_cmd_row,
    output logic [7:0]                         o_cmd_col,
    output logic [$clog2(ARG_SLOTS+1)-1:0]     o_cmd_cnt,
    output acsi_pkg::t_slot [ARG_SLOTS-1:0]    o_cmd_slots
);
    import acsi_pkg::*;

    localparam int unsigned DC_W  = $clog2(DIGIT_LIMIT + 1);
    localparam int unsigned CNT_W = $clog2(ARG_SLOTS + 1);
    localparam int unsigned IDX_W = $clog2(ARG_SLOTS);

    t_mode              r_mode, n_mode;
    logic [DC_W-1:0]    r_dc, n_dc;
    logic [15:0]        r_acc, n_acc;
    logic [CNT_W-1:0]   r_argc, n_argc;
    logic [15:0]        r_store [ARG_SLOTS];
    logic [7:0]         r_sv_row, r_sv_col;
    logic               st_we;
    logic               save_cur;

    logic               accept;
    logic [7:0]         ch;
    logic               is_digit, is_letter, is_semi;
    logic               dc_full, slots_full;
    logic [19:0]        acc_x10;
    logic [15:0]        acc_sat;
    logic [15:0]        a0, a1;
    logic [16:0]        row_up, col_up;
    t_slot [ARG_SLOTS-1:0] sgr_slots;
    logic [CNT_W-1:0]   sgr_cnt;

    assign ch        = i_in.ch;
    assign i_in.ready = !i_full;
    assign accept    = i_in.valid && !i_full;
    assign o_push    = accept;

    assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
    assign is_semi   = (ch == CH_SEMI);
    assign is_letter = ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) ||
                       ((ch >= CH_LC_A) && (ch <= CH_LC_Z));
    assign dc_full    = (r_dc >= DC_W'(DIGIT_LIMIT));
    assign slots_full = (r_argc >= CNT_W'(ARG_SLOTS));

    // acc*10 + digit, clamped to 16 bits
    assign acc_x10 = 20'({r_acc, 3'b000}) + 20'({r_acc, 1'b0}) + 20'(ch[3:0]);
    assign acc_sat = (|acc_x10[19:16]) ? 16'hFFFF : acc_x10[15:0];

    // arguments as they stand once the pending number is pushed
    assign a0 = (r_argc == '0) ? r_acc : r_store[0];
    always_comb begin
        if (r_argc == CNT_W'(1)) begin
            a1 = r_acc;
        end else if (r_argc > CNT_W'(1)) begin
            a1 = r_store[1];
        end else begin
            a1 = 16'd0;
        end
    end

    assign row_up = 17'(i_in.cur_row) + 17'(a0);
    assign col_up = 17'(i_in.cur_col) + 17'(a0);

    // SGR words, decoded in parallel per slot
    for (genvar gi = 0; gi < ARG_SLOTS; gi++) begin : g_sgr
        logic [15:0] v;
        assign v = (CNT_W'(gi) == r_argc) ? r_acc : r_store[gi];
        assign sgr_slots[gi] = (CNT_W'(gi) <= r_argc) ? sgr_decode(v) : t_slot'('0);
    end
    assign sgr_cnt = slots_full ? CNT_W'(ARG_SLOTS) : r_argc + 1'b1;

    // next parse mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_NORMAL: begin
                if (ch == CH_ESC) begin
                    n_mode = MODE_BRACKET;
                end
            end
            MODE_BRACKET: begin
                n_mode = (ch == CH_LBRACK) ? MODE_PARAMS : MODE_NORMAL;
            end
            MODE_PARAMS: begin
                if ((is_digit && dc_full) || is_letter) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: n_mode = MODE_NORMAL;
        endcase
    end

    // argument accumulation
    always_comb begin
        n_dc     = r_dc;
        n_acc    = r_acc;
        n_argc   = r_argc;
        st_we    = 1'b0;
        save_cur = 1'b0;
        case (r_mode)
            MODE_NORMAL: begin
            end
            MODE_BRACKET: begin
                if (ch == CH_LBRACK) begin
                    n_dc   = '0;
                    n_acc  = '0;
                    n_argc = '0;
                end
            end
            MODE_PARAMS: begin
                if (is_semi) begin
                    st_we  = !slots_full;
                    n_argc = slots_full ? r_argc : r_argc + 1'b1;
                    n_acc  = '0;
                    n_dc   = '0;
                end else if (is_digit) begin
                    if (dc_full) begin
                        n_dc   = '0;
                        n_acc  = '0;
                        n_argc = '0;
                    end else begin
                        n_acc = acc_sat;
                        n_dc  = r_dc + 1'b1;
                    end
                end else if (is_letter) begin
                    save_cur = (ch == CH_SAVE);
                    n_dc     = '0;
                    n_acc    = '0;
                    n_argc   = '0;
                end
            end
            default: begin
                n_dc   = '0;
                n_acc  = '0;
                n_argc = '0;
            end
        endcase
    end

    // command for this character
    always_comb begin
        o_cmd_cons  = 1'b0;
        o_cmd_row   = 8'd0;
        o_cmd_col   = 8'd0;
        o_cmd_cnt   = CNT_W'(1);
        o_cmd_slots = '0;
        case (r_mode)
            MODE_NORMAL:  o_cmd_cons = (ch == CH_ESC);
            MODE_BRACKET: o_cmd_cons = (ch == CH_LBRACK);
            MODE_PARAMS: begin
                o_cmd_cons = 1'b1;
                if (is_letter) begin
                    case (ch)
                        CH_RESTORE: begin
                            o_cmd_slots[0].action = ACT_SET_BOTH;
                            o_cmd_row = r_sv_row;
                            o_cmd_col = r_sv_col;
                        end
                        CH_ERASE: begin
                            if (i_in.cur_col < i_line_width) begin
                                o_cmd_slots[0].action = ACT_ERASE;
                                o_cmd_row = i_in.cur_row;
                                o_cmd_col = i_in.cur_col;
                            end
                        end
                        CH_HOME, CH_HVP: begin
                            o_cmd_slots[0].action = ACT_SET_BOTH;
                            o_cmd_row = sat8(17'(a0));
                            o_cmd_col = sat8(17'(a1));
                        end
                        CH_UP: begin
                            o_cmd_slots[0].action = ACT_SET_ROW;
                            o_cmd_row = (a0 >= 16'(i_in.cur_row)) ? 8'd0
                                                                  : i_in.cur_row - a0[7:0];
                            o_cmd_col = i_in.cur_col;
                        end
                        CH_DOWN: begin
                            o_cmd_slots[0].action = ACT_SET_ROW;
                            o_cmd_row = sat8(row_up);
                            o_cmd_col = i_in.cur_col;
                        end
                        CH_RIGHT: begin
                            o_cmd_slots[0].action = ACT_SET_COL;
                            o_cmd_row = i_in.cur_row;
                            o_cmd_col = sat8(col_up);
                        end
                        CH_LEFT: begin
                            o_cmd_slots[0].action = ACT_SET_COL;
                            o_cmd_row = i_in.cur_row;
                            o_cmd_col = (a0 >= 16'(i_in.cur_col)) ? 8'd0
                                                                  : i_in.cur_col - a0[7:0];
                        end
                        CH_CLEAR: begin
                            if (a0 == CLEAR_ALL) begin
                                o_cmd_slots[0].action = ACT_CLEAR;
                            end
                        end
                        CH_SGR: begin
                            o_cmd_slots = sgr_slots;
                            o_cmd_cnt   = sgr_cnt;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: o_cmd_cons = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_dc     <= '0;
            r_acc    <= '0;
            r_argc   <= '0;
            r_sv_row <= 8'd0;
            r_sv_col <= 8'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_dc   <= n_dc;
            r_acc  <= n_acc;
            r_argc <= n_argc;
            if (save_cur) begin
                r_sv_row <= i_in.cur_row;
                r_sv_col <= i_in.cur_col;
            end
        end
    end

    // slots above the count are never read, so no reset
    always_ff @(posedge i_clk) begin
        if (accept && st_we) begin
            r_store[r_argc[IDX_W-1:0]] <= r_acc;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/acsi_back.sv
// Result sequencer: pops commands and sends one result word per slot
// through a registered output stage. Depends on acsi_pkg, acsi_if.
`default_nettype none

module acsi_back #(
    parameter int unsigned ARG_SLOTS = acsi_pkg::ARG_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  acsi_pkg::t_q_status                i_status,
    output logic                               o_pop,
    input  logic                               i_cmd_cons,
    input  logic [7:0]                         i_cmd_row,
    input  logic [7:0]                         i_cmd_col,
    input  logic [$clog2(ARG_SLOTS+1)-1:0]     i_cmd_cnt,
    input  acsi_pkg::t_slot [ARG_SLOTS-1:0]    i_cmd_slots,
    acsi_out_if.source                         o_out
);
    import acsi_pkg::*;

    localparam int unsigned CNT_W = $clog2(ARG_SLOTS + 1);
    localparam int unsigned IDX_W = $clog2(ARG_SLOTS);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid;
    logic             r_cons;
    t_slot            r_slot;
    logic [7:0]       r_row, r_col;
    logic             r_last;
    logic             load;
    logic             head_last;

    assign head_last = ((CNT_W'(r_idx) + CNT_W'(1)) == i_cmd_cnt);
    assign load      = !i_status.empty && (!r_valid || o_out.ready);
    assign o_pop     = load && head_last;
    assign n_idx     = head_last ? '0 : r_idx + 1'b1;

    assign o_out.valid      = r_valid;
    assign o_out.consumed   = r_cons;
    assign o_out.action     = r_slot.action;
    assign o_out.attr_value = r_slot.attr;
    assign o_out.row        = r_row;
    assign o_out.col        = r_col;
    assign o_out.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cons <= i_cmd_cons;
            r_slot <= i_cmd_slots[r_idx];
            r_row  <= i_cmd_row;
            r_col  <= i_cmd_col;
            r_last <= head_last;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ansi_csi_escape_parser_top.sv
// Path: a character word taken is written into the command queue, and its first result word
//   is then loaded from the queue head into the output register that drives o_out.
// Throughput: one character word per cycle while the queue is not full; an SGR 'm' letter
//   holds the sequencer for one result word per stored argument (1..ARG_SLOTS), and the front
//   end runs on until the command queue (QUEUE_DEPTH entries) fills.
// Reset: synchronous, active low; clears parser state, saved cursor, queue and output
//   stage, and sets line_width to 80. No clearing pass: ready straight out of reset.
`default_nettype none

module ansi_csi_escape_parser_top #(
    parameter int unsigned DIGIT_LIMIT = acsi_pkg::DIGIT_LIMIT_DEF,
    parameter int unsigned ARG_SLOTS   = acsi_pkg::ARG_SLOTS_DEF,
    parameter int unsigned QUEUE_DEPTH = acsi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    acsi_in_if.sink                       i_in,
    acsi_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [acsi_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import acsi_pkg::*;

    localparam int unsigned CNT_W  = $clog2(ARG_SLOTS + 1);
    localparam int unsigned SLOT_W = $bits(t_slot);
    // queue word: consumed, row, col, result count, per-slot action/attr
    localparam int unsigned CMD_W  = 1 + 8 + 8 + CNT_W + ARG_SLOTS * SLOT_W;

    // ---------------------------------------------------------------
    // Configuration register. Registers sit on 32-bit word addresses;
    // the low two address bits are ignored.
    // ---------------------------------------------------------------
    logic [7:0] r_line_width;
    logic       reg_sel;
    logic       cfg_wr;

    assign reg_sel = (paddr[PADDR_W-1:2] == REG_LINE_WIDTH);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {24'd0, r_line_width} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RST;
        end else if (cfg_wr && reg_sel) begin
            r_line_width <= pwdata[7:0];
        end
    end

    // ---------------------------------------------------------------
    // Front end: parses one character word per cycle while the queue is not
    // full and writes one command per character into the queue.
    // ---------------------------------------------------------------
    logic                   push;
    logic                   f_cons;
    logic [7:0]             f_row, f_col;
    logic [CNT_W-1:0]       f_cnt;
    t_slot [ARG_SLOTS-1:0]  f_slots;
    t_q_status              q_status;

    acsi_front #(
        .DIGIT_LIMIT (DIGIT_LIMIT),
        .ARG_SLOTS   (ARG_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_line_width (r_line_width),
        .i_full       (q_status.full),
        .o_push       (push),
        .o_cmd_cons   (f_cons),
        .o_cmd_row    (f_row),
        .o_cmd_col    (f_col),
        .o_cmd_cnt    (f_cnt),
        .o_cmd_slots  (f_slots)
    );

    // ---------------------------------------------------------------
    // Command queue: lets the parser run on while a multi-result SGR
    // command is still being sent out.
    // ---------------------------------------------------------------
    logic [CMD_W-1:0]       q_wdata, q_rdata;
    logic                   pop;
    logic                   b_cons;
    logic [7:0]             b_row, b_col;
    logic [CNT_W-1:0]       b_cnt;
    t_slot [ARG_SLOTS-1:0]  b_slots;

    assign q_wdata = {f_cons, f_row, f_col, f_cnt, f_slots};
    assign {b_cons, b_row, b_col, b_cnt, b_slots} = q_rdata;

    acsi_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (q_wdata),
        .i_pop    (pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    // ---------------------------------------------------------------
    // Back end: one result word per cycle from the queue head while o_out is
    // not stalled, with last set on the final word of each command.
    // ---------------------------------------------------------------
    acsi_back #(
        .ARG_SLOTS (ARG_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (q_status),
        .o_pop       (pop),
        .i_cmd_cons  (b_cons),
        .i_cmd_row   (b_row),
        .i_cmd_col   (b_col),
        .i_cmd_cnt   (b_cnt),
        .i_cmd_slots (b_slots),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> hw/rtl/acsi_checker.sv
// Port-level checks of the escape parser, bound onto the top level.
// Depends on acsi_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module acsi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_consumed,
    input logic [3:0] i_out_action,
    input logic [7:0] i_out_row,
    input logic [7:0] i_out_col,
    input logic [3:0] i_out_attr_value,
    input logic       i_out_last
);
    import acsi_pkg::*;

    // stalled result word holds
    `ACSI_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_action) && $stable(i_out_row) && $stable(i_out_col) && $stable(i_out_attr_value) && $stable(i_out_last) && $stable(i_out_consumed), "result word changed while stalled")

    // printed characters give exactly one plain word
    `ACSI_ASSERT_IMP(a_plain_single, i_out_valid && !i_out_consumed, i_out_action == ACT_NONE && i_out_last && i_out_attr_value == 4'd0, "printed char gave a command")

    `ACSI_ASSERT_IMP(a_action_range, i_out_valid, i_out_action <= ACT_BG, "action code out of range")

    // attribute words carry no cursor position
    `ACSI_ASSERT_IMP(a_attr_no_pos, i_out_valid && (i_out_action == ACT_BLINK || i_out_action == ACT_FG || i_out_action == ACT_BG), i_out_row == 8'd0 && i_out_col == 8'd0, "attribute word with position")

    `ACSI_ASSERT_RST(a_reset_idle, !i_rst_n, !i_out_valid, "result valid after reset")

endmodule

bind ansi_csi_escape_parser_top acsi_checker u_acsi_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_consumed   (o_out.consumed),
    .i_out_action     (o_out.action),
    .i_out_row        (o_out.row),
    .i_out_col        (o_out.col),
    .i_out_attr_value (o_out.attr_value),
    .i_out_last       (o_out.last)
);

`default_nettype wire
